>>> design/pce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants of the Pearson correlation engine
// Transaction payloads, the operation codes of the shared arithmetic unit and
// the width helper that both the top level and the unit use.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int COST_W     = 16;
  localparam int CORR_W     = 16;
  localparam int PCOUNT_W   = 17;
  // Working width for the signed coefficient before it is cut to CORR_W.
  localparam int MAG_CALC_W = 32;

  // Parameter defaults.
  localparam int COST_BITS_DEF = 16;
  localparam int MAX_PAIRS_DEF = 65536;
  localparam int FRAC_BITS_DEF = 14;

  typedef struct packed {
    logic [COST_W-1:0] cost_a;
    logic [COST_W-1:0] cost_b;
    logic              last_pair;
  } pair_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     degenerate;
    logic [PCOUNT_W-1:0]      pair_count;
  } result_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIV  = 2'd2,
    OP_SQRT = 2'd3
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Width that holds any covariance or variance term n*Sxy - Sx*Sy.
  function automatic int var_width(input int cost_bits, input int max_pairs);
    return 2 * cost_bits + 2 * $clog2(max_pairs);
  endfunction

endpackage
`default_nettype wire

>>> design/pce_arith.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_arith: shared wide arithmetic unit
// One wide adder serves a shift-add multiply, a subtract, a restoring divide
// of the last product by a divisor and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module pce_arith import pce_pkg::*; #(
  parameter int COST_BITS = COST_BITS_DEF,
  parameter int MAX_PAIRS = MAX_PAIRS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int V_W = var_width(COST_BITS, MAX_PAIRS),
  localparam int P_W = 2 * V_W,
  localparam int R_W = FRAC_BITS + 1
) (
  input  logic            clk,
  input  logic            rst,
  input  unit_req_t       req,
  input  logic [P_W-1:0]  a,
  input  logic [V_W-1:0]  b,
  output unit_sts_t       sts,
  output logic [P_W:0]    res,
  output logic [R_W-1:0]  root
);

  localparam int Q_W = 2 * FRAC_BITS + 1;
  localparam int D_W = 2 * FRAC_BITS + 2;
  localparam int X_W = (P_W + 1 > FRAC_BITS + 4) ? P_W + 1 : FRAC_BITS + 4;
  localparam int Z_W = (V_W > D_W) ? V_W : D_W;
  localparam int K_W = $clog2(Q_W + 1);

  logic           busy;
  op_t            op_r;
  logic [K_W-1:0] cnt;
  logic [X_W-1:0] x;
  logic [P_W-1:0] y;
  logic [Z_W-1:0] z;

  logic [X_W-1:0] remsh, trial, opl, opr, sum;
  logic           sub_mode, below, finish;

  always_comb begin
    remsh    = {x[X_W-3:0], z[D_W-1 -: 2]};
    trial    = X_W'({root, 2'b01});
    sub_mode = (op_r != OP_MUL);
    opl      = (op_r == OP_SQRT) ? remsh : x;
    opr      = (op_r == OP_SQRT) ? trial : X_W'(y);
    sum      = opl + (sub_mode ? ~opr : opr) + X_W'(sub_mode);
    below    = sum[X_W-1];
    case (op_r)
      OP_MUL:  finish = (z == '0);
      OP_SUB:  finish = (cnt == K_W'(1));
      OP_DIV:  finish = (cnt == K_W'(Q_W));
      OP_SQRT: finish = (cnt == K_W'(R_W));
      default: finish = 1'b1;
    endcase
  end

  assign sts.busy = busy;
  assign sts.done = busy & finish;
  assign res      = x[P_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      op_r <= OP_MUL;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      op_r <= req.op;
      cnt  <= '0;
    end else if (busy) begin
      if (finish) begin
        busy <= 1'b0;
      end else if (op_r != OP_MUL) begin
        cnt <= cnt + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      case (req.op)
        OP_MUL: begin
          x <= '0;
          y <= a;
          z <= Z_W'(b);
        end
        OP_SUB: begin
          x <= X_W'(a);
          y <= P_W'(b);
        end
        OP_DIV: begin
          // dividend stays in x from the preceding multiply
          y <= a;
          z <= '0;
        end
        OP_SQRT: begin
          // radicand stays in z from the preceding divide
          x    <= '0;
          root <= '0;
        end
        default: ;
      endcase
    end else if (busy && !finish) begin
      case (op_r)
        OP_MUL: begin
          if (z[0]) begin
            x <= sum;
          end
          y <= {y[P_W-2:0], 1'b0};
          z <= {1'b0, z[Z_W-1:1]};
        end
        OP_SUB: begin
          x <= sum;
        end
        OP_DIV: begin
          x <= below ? {x[X_W-2:0], 1'b0} : {sum[X_W-2:0], 1'b0};
          z <= {z[Z_W-2:0], ~below};
        end
        OP_SQRT: begin
          x    <= below ? remsh : sum;
          root <= {root[R_W-2:0], ~below};
          z    <= {z[Z_W-3:0], 2'b00};
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/pearson_correlation_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pearson_correlation_engine: streaming Pearson coefficient of cost pairs
// Pairs (cost_a, cost_b) arrive on the pair channel, each transaction one
// pair; last_pair closes a data set. Exact integer sums of a, b, a*a, b*b and
// a*b are kept, and on the closing pair the engine forms
//   r = (n*Sab - Sa*Sb) / sqrt((n*Saa - Sa^2) * (n*Sbb - Sb^2))
// and sends it on the result channel as a signed fixed-point value with
// FRAC_BITS fraction bits (16384 reads 1.0 at the default), truncated toward
// zero. A zero variance gives correlation 0 with degenerate set. Pairs beyond
// MAX_PAIRS are dropped but a closing flag on them still fires the result.
// Each accepted pair holds off the pair channel while the one cost multiplier
// forms a*a, b*b and a*b in turn. The closing pair then holds off the pair
// channel while the shared shift-add unit runs up to eight products, the
// subtracts, the divide and the root, one after another.
// Reset clears all sums and drops any held result. A result waits in the
// output register while the receiver stalls; the next data set accumulates
// meanwhile, and only its own result waits for the register to free up.
// ----------------------------------------------------------------------------
module pearson_correlation_engine import pce_pkg::*; #(
  parameter int COST_BITS = COST_BITS_DEF,
  parameter int MAX_PAIRS = MAX_PAIRS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    pair_valid,
  output logic    pair_ready,
  input  pair_t   pair,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int L_W   = $clog2(MAX_PAIRS);
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int S1_W  = COST_BITS + L_W;
  localparam int S2_W  = 2 * COST_BITS + L_W;
  localparam int SQ_W  = 2 * COST_BITS;
  localparam int V_W   = var_width(COST_BITS, MAX_PAIRS);
  localparam int P_W   = 2 * V_W;
  localparam int R_W   = FRAC_BITS + 1;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_ACC_AA = 19'h00002,
    S_ACC_BB = 19'h00004,
    S_ACC_AB = 19'h00008,
    S_NAB    = 19'h00010,
    S_SASB   = 19'h00020,
    S_COV    = 19'h00040,
    S_COVN   = 19'h00080,
    S_NAA    = 19'h00100,
    S_SAA    = 19'h00200,
    S_VA     = 19'h00400,
    S_NBB    = 19'h00800,
    S_SBB    = 19'h01000,
    S_VB     = 19'h02000,
    S_PROD   = 19'h04000,
    S_CC     = 19'h08000,
    S_DIV    = 19'h10000,
    S_SQRT   = 19'h20000,
    S_DONE   = 19'h40000
  } state_t;

  // Control
  state_t state, state_next;
  logic   launched;
  logic   is_op;
  logic   load_result;
  op_t    op;

  // Running sums
  logic [CNT_W-1:0] count;
  logic [S1_W-1:0]  sum_a, sum_b;
  logic [S2_W-1:0]  sum_aa, sum_bb, sum_ab;

  // Current pair and the one cost multiplier
  logic [COST_BITS-1:0] cur_a, cur_b, mul_x, mul_y;
  logic                 cur_last;
  logic [SQ_W-1:0]      sq;

  // Finishing datapath
  logic [V_W-1:0]  hp, hq, cov, va;
  logic [P_W-1:0]  prod;
  logic            cov_neg, deg;
  logic [P_W-1:0]  opa;
  logic [V_W-1:0]  opb;
  logic [P_W:0]    res;
  logic [V_W-1:0]  res_v;
  logic [R_W-1:0]  root;
  logic [MAG_CALC_W-1:0] mag_ext, corr_ext;

  unit_req_t req;
  unit_sts_t sts;

  pce_arith #(
    .COST_BITS (COST_BITS),
    .MAX_PAIRS (MAX_PAIRS),
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (opa),
    .b    (opb),
    .sts  (sts),
    .res  (res),
    .root (root)
  );

  assign pair_ready  = (state == S_IDLE);
  assign load_result = (state == S_DONE) && (!result_valid || result_ready);
  assign res_v       = res[V_W-1:0];

  // Cost multiplier: a*a, then b*b, then a*b on successive cycles.
  always_comb begin
    mul_x = (state == S_ACC_BB) ? cur_b : cur_a;
    mul_y = (state == S_ACC_AA) ? cur_a : cur_b;
    sq    = SQ_W'(mul_x) * SQ_W'(mul_y);
  end

  // Operation schedule of the finishing sequence: operands, code and the
  // state that follows once the unit reports done.
  always_comb begin
    is_op      = 1'b1;
    op         = OP_MUL;
    opa        = '0;
    opb        = '0;
    state_next = S_IDLE;
    case (state)
      S_NAB: begin
        opa        = P_W'(sum_ab);
        opb        = V_W'(count);
        state_next = S_SASB;
      end
      S_SASB: begin
        opa        = P_W'(sum_a);
        opb        = V_W'(sum_b);
        state_next = S_COV;
      end
      S_COV: begin
        op  = OP_SUB;
        opa = P_W'(hp);
        opb = hq;
        // a borrow means the covariance is negative: redo it the other way
        state_next = res[P_W] ? S_COVN : S_NAA;
      end
      S_COVN: begin
        op         = OP_SUB;
        opa        = P_W'(hq);
        opb        = hp;
        state_next = S_NAA;
      end
      S_NAA: begin
        opa        = P_W'(sum_aa);
        opb        = V_W'(count);
        state_next = S_SAA;
      end
      S_SAA: begin
        opa        = P_W'(sum_a);
        opb        = V_W'(sum_a);
        state_next = S_VA;
      end
      S_VA: begin
        op         = OP_SUB;
        opa        = P_W'(hp);
        opb        = hq;
        state_next = S_NBB;
      end
      S_NBB: begin
        opa        = P_W'(sum_bb);
        opb        = V_W'(count);
        state_next = S_SBB;
      end
      S_SBB: begin
        opa        = P_W'(sum_b);
        opb        = V_W'(sum_b);
        state_next = S_VB;
      end
      S_VB: begin
        op  = OP_SUB;
        opa = P_W'(hp);
        opb = hq;
        // skip the divide and root when either variance is zero
        state_next = ((va == '0) || (res_v == '0)) ? S_DONE : S_PROD;
      end
      S_PROD: begin
        opa        = P_W'(va);
        opb        = hp;
        state_next = S_CC;
      end
      S_CC: begin
        opa        = P_W'(cov);
        opb        = cov;
        state_next = S_DIV;
      end
      S_DIV: begin
        // cov^2 is still in the unit; divide it (scaled) by Va*Vb
        op         = OP_DIV;
        opa        = prod;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        op         = OP_SQRT;
        state_next = S_DONE;
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
  end

  assign req.start = is_op & ~launched;
  assign req.op    = op;

  // Sequencer, running sums and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launched     <= 1'b0;
      result_valid <= 1'b0;
      count        <= '0;
      sum_a        <= '0;
      sum_b        <= '0;
      sum_aa       <= '0;
      sum_bb       <= '0;
      sum_ab       <= '0;
    end else begin
      // load a fresh result, or drop valid once the held one is taken
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pair_valid) begin
            // drop pairs once the data set is full, but honour the last flag
            if (count < CNT_W'(MAX_PAIRS)) begin
              state <= S_ACC_AA;
            end else if (pair.last_pair) begin
              state <= S_NAB;
            end
          end
        end
        S_ACC_AA: begin
          count  <= count + CNT_W'(1);
          sum_a  <= sum_a + S1_W'(cur_a);
          sum_b  <= sum_b + S1_W'(cur_b);
          sum_aa <= sum_aa + S2_W'(sq);
          state  <= S_ACC_BB;
        end
        S_ACC_BB: begin
          sum_bb <= sum_bb + S2_W'(sq);
          state  <= S_ACC_AB;
        end
        S_ACC_AB: begin
          sum_ab <= sum_ab + S2_W'(sq);
          state  <= cur_last ? S_NAB : S_IDLE;
        end
        S_DONE: begin
          // hold here until the output register is free, then clear the sums
          if (load_result) begin
            count  <= '0;
            sum_a  <= '0;
            sum_b  <= '0;
            sum_aa <= '0;
            sum_bb <= '0;
            sum_ab <= '0;
            state  <= S_IDLE;
          end
        end
        default: begin
          if (!is_op) begin
            state <= S_IDLE;
          end else if (!launched) begin
            launched <= 1'b1;
          end else if (sts.done) begin
            launched <= 1'b0;
            state    <= state_next;
          end
        end
      endcase
    end
  end

  // Capture intermediate terms as each operation completes.
  always_ff @(posedge clk) begin
    if (pair_valid && pair_ready) begin
      cur_a    <= COST_BITS'(pair.cost_a);
      cur_b    <= COST_BITS'(pair.cost_b);
      cur_last <= pair.last_pair;
    end
    if (sts.done) begin
      case (state)
        S_NAB, S_NAA, S_NBB: hp <= res_v;
        S_SASB, S_SAA, S_SBB: hq <= res_v;
        S_COV: begin
          cov     <= res_v;
          cov_neg <= res[P_W];
        end
        S_COVN: cov <= res_v;
        S_VA:   va  <= res_v;
        S_VB: begin
          hp  <= res_v;
          deg <= (va == '0) || (res_v == '0);
        end
        S_PROD: prod <= res[P_W-1:0];
        default: ;
      endcase
    end
    if (load_result) begin
      result.correlation <= corr_ext[CORR_W-1:0];
      result.degenerate  <= deg;
      result.pair_count  <= PCOUNT_W'(count);
    end
  end

  // Apply the sign of the covariance to the root magnitude.
  always_comb begin
    mag_ext  = deg ? '0 : MAG_CALC_W'(root);
    corr_ext = cov_neg ? (~mag_ext + MAG_CALC_W'(1)) : mag_ext;
  end

  // Never start the shared unit while an operation is still running.
  a_start_free : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !sts.busy)
    else $error("shared unit started while busy");

  // Pairs are taken only with the unit quiet.
  a_ready_quiet : assert property (@(posedge clk) disable iff (rst)
    pair_ready |-> (!sts.busy && !launched))
    else $error("pair channel ready during a unit operation");

  // A degenerate result always carries a zero coefficient.
  a_deg_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.degenerate) |-> (result.correlation == '0))
    else $error("degenerate result with non-zero correlation");

  // The sums are clear when a fresh result appears.
  a_clear : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> (count == '0))
    else $error("pair count not cleared after result");

endmodule
`default_nettype wire
